/* hw/rtl/atp_pkg.sv */
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types, widths and the arctangent table of the tilt block.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int RAW_W        = 8;   // one raw data byte
  localparam int AXIS_W       = 15;  // negated 14-bit axis value
  localparam int ANGLE_W      = 15;  // angle field width
  localparam int SQR_W        = 27;  // square of one axis value
  localparam int RAD_W        = 28;  // sum of two squares
  localparam int NUM_SHIFT    = 30;  // vector scale 2^30
  localparam int ROOT_W       = 44;  // floor(sqrt(R) * 2^30)
  localparam int VEC_W        = 50;  // cordic vector width, with growth margin
  localparam int ACC_W        = 49;  // angle accumulator, 1e-12 degree units
  localparam int TAB_W        = 48;
  localparam int CORDIC_STEPS = 40;
  localparam int SQRT_LAT     = ROOT_W;
  localparam int CORDIC_LAT   = CORDIC_STEPS;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [RAD_W-1:0]         rad_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // side flags that travel with one lane item
  typedef struct packed {
    logic zero;  // sum of squares is zero
    logic pos;   // numerator above zero
    logic neg;   // numerator below zero
  } atp_flags_t;

  // round(atan(2^-i) in degrees * 1e12)
  localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    48'd45000000000000, 48'd26565051177078, 48'd14036243467926, 48'd7125016348902,
    48'd3576334374997,  48'd1789910608246,  48'd895173710211,   48'd447614170861,
    48'd223810500369,   48'd111905677066,   48'd55952891894,    48'd27976452617,
    48'd13988227142,    48'd6994113675,     48'd3497056851,     48'd1748528427,
    48'd874264214,      48'd437132107,      48'd218566053,      48'd109283027,
    48'd54641513,       48'd27320757,       48'd13660378,       48'd6830189,
    48'd3415095,        48'd1707547,        48'd853774,         48'd426887,
    48'd213443,         48'd106722,         48'd53361,          48'd26680,
    48'd13340,          48'd6670,           48'd3335,           48'd1668,
    48'd834,            48'd417,            48'd208,            48'd104
  };

endpackage

/* hw/rtl/atp_if.sv */
// ----------------------------------------------------------------------------
// atp_in_if / atp_out_if
// Valid/ready channels of the tilt block: raw sample in, axes and angles out.
// ----------------------------------------------------------------------------
interface atp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_high;
  logic [7:0] x_low;
  logic [7:0] y_high;
  logic [7:0] y_low;
  logic [7:0] z_high;
  logic [7:0] z_low;

  modport source (output valid, x_high, x_low, y_high, y_low, z_high, z_low,
                  input ready);
  modport sink   (input valid, x_high, x_low, y_high, y_low, z_high, z_low,
                  output ready);
endinterface

interface atp_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] accel_x;
  logic signed [14:0] accel_y;
  logic signed [14:0] accel_z;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] roll_angle;

  modport source (output valid, accel_x, accel_y, accel_z, pitch_angle, roll_angle,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, pitch_angle, roll_angle,
                  output ready);
endinterface

/* hw/rtl/atp_isqrt.sv */
// ----------------------------------------------------------------------------
// atp_isqrt
// Pipelined digit-by-digit square root, one root bit per stage:
// root = floor(sqrt(R * 2^60)).
// ----------------------------------------------------------------------------
module atp_isqrt
  import atp_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  rad_t             r_in,
  input  logic [TAG_W-1:0] tag_in,
  output root_t            root_out,
  output logic [TAG_W-1:0] tag_out
);

  localparam int REM_W = 2 * ROOT_W + 1;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  root_t             root_q [ROOT_W];
  logic [TAG_W-1:0]  tag_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [REM_W-1:0] rem_p;
    root_t            root_p;
    logic [TAG_W-1:0] tag_p;
    logic [REM_W-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_p  = REM_W'({r_in, {(2 * NUM_SHIFT){1'b0}}});
      assign root_p = '0;
      assign tag_p  = tag_in;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign tag_p  = tag_q[s-1];
    end

    // (root + 2^b)^2 - root^2
    assign trial = (REM_W'(root_p) << (B + 1)) | (REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[s] <= tag_p;
        if (rem_p >= trial) begin
          rem_q[s]  <= rem_p - trial;
          root_q[s] <= root_p | (ROOT_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_p;
          root_q[s] <= root_p;
        end
      end
    end
  end

  assign root_out = root_q[ROOT_W-1];
  assign tag_out  = tag_q[ROOT_W-1];

endmodule

/* hw/rtl/atp_cordic.sv */
// ----------------------------------------------------------------------------
// atp_cordic
// Pipelined cordic in vectoring mode, one micro-rotation per stage,
// angle accumulated in units of 1e-12 degree.
// ----------------------------------------------------------------------------
module atp_cordic
  import atp_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  root_t            vx_in,
  input  axis_t            num_in,
  input  logic [TAG_W-1:0] tag_in,
  output acc_t             acc_out,
  output logic [TAG_W-1:0] tag_out
);

  logic signed [VEC_W-1:0] vx_q  [CORDIC_STEPS];
  logic signed [VEC_W-1:0] vy_q  [CORDIC_STEPS];
  acc_t                    acc_q [CORDIC_STEPS];
  logic [TAG_W-1:0]        tag_q [CORDIC_STEPS];

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    logic signed [VEC_W-1:0] vx_p, vy_p, dx, dy;
    acc_t                    acc_p;
    logic [TAG_W-1:0]        tag_p;

    if (s == 0) begin : g_first
      assign vx_p  = $signed({{(VEC_W - ROOT_W){1'b0}}, vx_in});
      assign vy_p  = $signed({{(VEC_W - AXIS_W){num_in[AXIS_W-1]}}, num_in}) <<< NUM_SHIFT;
      assign acc_p = '0;
      assign tag_p = tag_in;
    end else begin : g_next
      assign vx_p  = vx_q[s-1];
      assign vy_p  = vy_q[s-1];
      assign acc_p = acc_q[s-1];
      assign tag_p = tag_q[s-1];
    end

    // arithmetic shift rounds toward minus infinity
    assign dx = vy_p >>> s;
    assign dy = vx_p >>> s;

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[s] <= tag_p;
        if (!vy_p[VEC_W-1]) begin
          vx_q[s]  <= vx_p + dx;
          vy_q[s]  <= vy_p - dy;
          acc_q[s] <= acc_p + $signed({1'b0, ATAN_TAB[s]});
        end else begin
          vx_q[s]  <= vx_p - dx;
          vy_q[s]  <= vy_p + dy;
          acc_q[s] <= acc_p - $signed({1'b0, ATAN_TAB[s]});
        end
      end
    end
  end

  assign acc_out = acc_q[CORDIC_STEPS-1];
  assign tag_out = tag_q[CORDIC_STEPS-1];

endmodule

/* hw/rtl/atp_scale.sv */
// ----------------------------------------------------------------------------
// atp_scale
// Converts the accumulated angle to 2^-FRAC degree with rounding half away
// from zero (pipelined restoring division by 1e12), clamps to +-90 degree
// and resolves the zero-root case.
// ----------------------------------------------------------------------------
module atp_scale
  import atp_pkg::*;
#(
  parameter int FRAC = 7
) (
  input  logic               clk,
  input  logic               en,
  input  acc_t               acc_in,
  input  atp_flags_t         flags_in,
  output logic [ANGLE_W-1:0] angle_out
);

  localparam int MW = ACC_W + FRAC;   // scaled magnitude plus half
  localparam int QW = FRAC + 7;       // quotient below 128 degrees
  localparam int EW = QW + ANGLE_W;
  localparam logic [MW-1:0] DIV  = MW'(40'd1000000000000);
  localparam logic [MW-1:0] HALF = MW'(40'd500000000000);
  localparam logic [QW-1:0] FULL = QW'(90) << FRAC;

  logic [ACC_W-2:0] mag;
  logic [MW-1:0]    m0;
  logic             sgn0;
  atp_flags_t       flg0;

  logic [MW-1:0]    rem_q [QW];
  logic [QW-1:0]    quo_q [QW];
  logic             sgn_q [QW];
  atp_flags_t       flg_q [QW];

  assign mag = acc_in[ACC_W-1] ? (ACC_W-1)'(-acc_in) : acc_in[ACC_W-2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      m0   <= (MW'(mag) << FRAC) + HALF;
      sgn0 <= acc_in[ACC_W-1];
      flg0 <= flags_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [MW-1:0] rem_p;
    logic [QW-1:0] quo_p;
    logic          sgn_p;
    atp_flags_t    flg_p;

    if (s == 0) begin : g_first
      assign rem_p = m0;
      assign quo_p = '0;
      assign sgn_p = sgn0;
      assign flg_p = flg0;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign quo_p = quo_q[s-1];
      assign sgn_p = sgn_q[s-1];
      assign flg_p = flg_q[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sgn_q[s] <= sgn_p;
        flg_q[s] <= flg_p;
        if (rem_p >= (DIV << K)) begin
          rem_q[s] <= rem_p - (DIV << K);
          quo_q[s] <= quo_p | (QW'(1) << K);
        end else begin
          rem_q[s] <= rem_p;
          quo_q[s] <= quo_p;
        end
      end
    end
  end

  logic [QW-1:0]   q_clamp;
  logic [EW-1:0]   q_ext, full_ext, ang;
  atp_flags_t      flg_l;

  assign flg_l    = flg_q[QW-1];
  assign q_clamp  = (quo_q[QW-1] > FULL) ? FULL : quo_q[QW-1];
  assign q_ext    = EW'(q_clamp);
  assign full_ext = EW'(FULL);

  always_comb begin
    if (flg_l.zero) begin
      if (flg_l.pos)      ang = full_ext;
      else if (flg_l.neg) ang = -full_ext;
      else                ang = '0;
    end else begin
      ang = sgn_q[QW-1] ? -q_ext : q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_out <= ang[ANGLE_W-1:0];
    end
  end

endmodule

/* hw/rtl/accel_tilt_pitch_roll_unit.sv */
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_unit
// Tilt angles from one raw three-axis accelerometer sample.
//
// sample channel: six raw data bytes per beat (high and low byte per axis).
// result channel: the three negated 14-bit axis values and the pitch and
//   roll angles in units of 2^-ANGLE_FRAC_BITS degree, one beat per sample.
// the design is a single pipeline with two lanes side by side: the pitch
//   lane works on x over sqrt(y^2+z^2), the roll lane on y over
//   sqrt(x^2+z^2); each lane is a square-root pipeline (one bit a stage,
//   44 stages), a cordic pipeline (40 stages) and a rounding divider
//   (ANGLE_FRAC_BITS+9 stages). a merge stage joins both angles with the
//   delayed axis values into the output register.
// throughput: one sample per cycle while the receiver does not stall.
// when the receiver stalls the whole pipeline holds and sample.ready drops
//   while the output register is full and not taken, and during reset.
// reset (rst, synchronous) clears all valid bits; data registers keep junk.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_unit
  import atp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic         clk,
  input  logic         rst,
  atp_in_if.sink       sample,
  atp_out_if.source    result
);

  localparam int SCALE_LAT = ANGLE_FRAC_BITS + 9;
  localparam int LANE_LAT  = SQRT_LAT + CORDIC_LAT + SCALE_LAT;
  localparam int PIPE      = 3 + LANE_LAT;
  localparam int NLANE     = 2;

  // global advance: output register free or being drained
  logic en;
  assign en           = !result.valid || result.ready;
  assign sample.ready = en && !rst;

  logic [PIPE-1:0] vld_q;

  // stage a: assemble, shift and negate each axis
  function automatic axis_t axis_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] w;
    axis_t       v;
    w = {hi, lo};
    v = $signed({w[15], w[15:2]});
    return -v;
  endfunction

  axis_t ax_a, ay_a, az_a;
  axis_t ax_b, ay_b, az_b;
  axis_t ax_c, ay_c, az_c;
  logic [SQR_W-1:0] xx_b, yy_b, zz_b;
  rad_t r_yz_c, r_xz_c;
  logic signed [2*AXIS_W-1:0] px, py, pz;

  assign px = ax_a * ax_a;
  assign py = ay_a * ay_a;
  assign pz = az_a * az_a;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_a <= axis_value(sample.x_high, sample.x_low);
      ay_a <= axis_value(sample.y_high, sample.y_low);
      az_a <= axis_value(sample.z_high, sample.z_low);
      // stage b: squares
      xx_b <= px[SQR_W-1:0];
      yy_b <= py[SQR_W-1:0];
      zz_b <= pz[SQR_W-1:0];
      ax_b <= ax_a;
      ay_b <= ay_a;
      az_b <= az_a;
      // stage c: sums under the roots
      r_yz_c <= RAD_W'(yy_b) + RAD_W'(zz_b);
      r_xz_c <= RAD_W'(xx_b) + RAD_W'(zz_b);
      ax_c   <= ax_b;
      ay_c   <= ay_b;
      az_c   <= az_b;
    end
  end

  // lanes: 0 pitch, 1 roll
  axis_t              lane_num [NLANE];
  rad_t               lane_rad [NLANE];
  logic [ANGLE_W-1:0] lane_ang [NLANE];

  assign lane_num[0] = ax_c;
  assign lane_rad[0] = r_yz_c;
  assign lane_num[1] = ay_c;
  assign lane_rad[1] = r_xz_c;

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    atp_flags_t flg_in, flg_sq, flg_co;
    root_t      root;
    axis_t      num_sq;
    acc_t       acc;

    assign flg_in.zero = (lane_rad[l] == '0);
    assign flg_in.pos  = !lane_num[l][AXIS_W-1] && (lane_num[l] != '0);
    assign flg_in.neg  = lane_num[l][AXIS_W-1];

    atp_isqrt #(.TAG_W($bits(atp_flags_t) + AXIS_W)) u_sqrt (
      .clk      (clk),
      .en       (en),
      .r_in     (lane_rad[l]),
      .tag_in   ({flg_in, lane_num[l]}),
      .root_out (root),
      .tag_out  ({flg_sq, num_sq})
    );

    atp_cordic #(.TAG_W($bits(atp_flags_t))) u_cordic (
      .clk     (clk),
      .en      (en),
      .vx_in   (root),
      .num_in  (num_sq),
      .tag_in  (flg_sq),
      .acc_out (acc),
      .tag_out (flg_co)
    );

    atp_scale #(.FRAC(ANGLE_FRAC_BITS)) u_scale (
      .clk       (clk),
      .en        (en),
      .acc_in    (acc),
      .flags_in  (flg_co),
      .angle_out (lane_ang[l])
    );
  end

  // axis values ride a delay line alongside the lanes
  logic [3*AXIS_W-1:0] axes_dly [LANE_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      axes_dly[0] <= {ax_c, ay_c, az_c};
      for (int k = 1; k < LANE_LAT; k++) begin
        axes_dly[k] <= axes_dly[k-1];
      end
    end
  end

  // valid bits and merge into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q        <= '0;
      result.valid <= 1'b0;
    end else if (en) begin
      vld_q        <= {vld_q[PIPE-2:0], sample.valid};
      result.valid <= vld_q[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {result.accel_x, result.accel_y, result.accel_z} <= axes_dly[LANE_LAT-1];
      result.pitch_angle <= $signed(lane_ang[0]);
      result.roll_angle  <= $signed(lane_ang[1]);
    end
  end

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // a result beat comes only from an item that reached the lane outputs
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(vld_q[PIPE-1]))
    else $error("result valid without a pipeline item");

  // angles stay within +-90 degree at the default format
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && ANGLE_FRAC_BITS == 7 |->
      result.pitch_angle <= 15'sd11520 && result.pitch_angle >= -15'sd11520)
    else $error("pitch out of range");

  // zero root for pitch gives only +-90 or 0
  a_pitch_zero_root: assert property (@(posedge clk) disable iff (rst)
    result.valid && ANGLE_FRAC_BITS == 7 && result.accel_y == '0 && result.accel_z == '0
      |-> result.pitch_angle == 15'sd11520 || result.pitch_angle == -15'sd11520 ||
          result.pitch_angle == '0)
    else $error("pitch zero-root case wrong");

endmodule
